// ===== src/gca_pkg.sv =====
// Shared constants, types and helpers for the grid clearance annotator.
package gca_pkg;

    localparam int MAX_SIDE = 64;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W   = COORD_W + 1;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int CLR_W    = 7;
    localparam int WORD_W   = CLR_W + 1;

    localparam logic [CLR_W-1:0] CLR_MAX = {CLR_W{1'b1}};

    // operation codes
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_CLEAR    = 2'd1;
    localparam logic [1:0] OP_ANNOTATE = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the incoming transaction
        logic wr_cell;   // write the latched cell
        logic clr_step;  // clear one memory word
        logic ann_step;  // issue reads for one annotate cell
        logic emit;      // produce the result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic ann_last;
    } t_sts;

    // clamp a side register to 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            res = SIDE_W'(MAX_SIDE);
        end
        return res;
    endfunction

endpackage

// ===== src/gca_ctrl.sv =====
// Controller state machine of the grid clearance annotator.
module gca_ctrl import gca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_operation,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_RDATA = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_ANN   = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_clr_op, n_clr_op;   // sweep belongs to a clear transaction, not reset

    always_comb begin
        n_state  = r_state;
        n_clr_op = r_clr_op;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_operation)
                        OP_WRITE:    n_state = S_WRITE;
                        OP_READ:     n_state = S_READ;
                        OP_ANNOTATE: n_state = S_ANN;
                        OP_CLEAR: begin
                            n_state  = S_CLEAR;
                            n_clr_op = 1'b1;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.wr_cell = 1'b1;
                o_cmd.emit    = 1'b1;
                n_state       = S_IDLE;
            end
            S_READ: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.emit = r_clr_op;
                    n_clr_op   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_ANN: begin
                o_cmd.ann_step = 1'b1;
                if (i_sts.ann_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last cell is written this cycle
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr_op <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr_op <= n_clr_op;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== src/gca_datapath.sv =====
// Datapath: grid memory, sweep counters, annotate stage and result registers.
module gca_datapath import gca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [1:0]         i_operation,
    input  logic [COORD_W-1:0] i_cell_x,
    input  logic [COORD_W-1:0] i_cell_y,
    input  logic               i_obstacle_flag,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_index,
    input  logic [SIDE_W-1:0]  i_cfg_data,
    output logic               o_done,
    output logic [CLR_W-1:0]   o_clearance,
    output logic               o_cell_blocked,
    output logic               o_out_of_range
);

    // word layout: {obstacle, clearance}
    logic [WORD_W-1:0]  r_mem [DEPTH];

    logic [SIDE_W-1:0]  r_w, r_h;
    logic [1:0]         r_op;
    logic [COORD_W-1:0] r_x, r_y;
    logic               r_flag;
    logic [ADDR_W-1:0]  r_clr_cnt;
    logic [COORD_W-1:0] r_gx, r_gy;
    logic               r_pv;
    logic [COORD_W-1:0] r_px, r_py;
    logic [WORD_W-1:0]  r_qa, r_qb;
    logic [WORD_W-1:0]  r_b, r_d;
    logic               r_done;
    logic [CLR_W-1:0]   r_clearance;
    logic               r_blocked, r_oor;

    logic               w_in_range;
    logic [ADDR_W-1:0]  w_addr_a, w_addr_b, w_waddr;
    logic [WORD_W-1:0]  w_wdata, w_ann_word;
    logic               w_we, w_border, w_nb_obst;
    logic [CLR_W-1:0]   w_min, w_inc, w_new_clr;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= SIDE_W'(MAX_SIDE);
            r_h <= SIDE_W'(MAX_SIDE);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_w <= sat_side(i_cfg_data);
                CFG_HEIGHT: r_h <= sat_side(i_cfg_data);
            endcase
        end
    end

    // latched transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_x    <= i_cell_x;
            r_y    <= i_cell_y;
            r_flag <= i_obstacle_flag;
        end
    end

    assign w_in_range = ({1'b0, r_x} < r_w) && ({1'b0, r_y} < r_h);

    // clear sweep counter, wraps back to zero at the end of each pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // annotate address generator: columns right to left, rows bottom to top
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gx <= COORD_W'(r_w - 1'b1);
            r_gy <= COORD_W'(r_h - 1'b1);
        end else if (i_cmd.ann_step) begin
            if (r_gy == '0) begin
                r_gy <= COORD_W'(r_h - 1'b1);
                r_gx <= r_gx - 1'b1;
            end else begin
                r_gy <= r_gy - 1'b1;
            end
        end
    end

    assign o_sts.clr_last = &r_clr_cnt;
    assign o_sts.ann_last = (r_gx == '0) && (r_gy == '0);

    // compute stage runs in the cycle after the read issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.ann_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= r_gx;
        r_py <= r_gy;
    end

    // port A: current cell; port B: right neighbour (wraps harmlessly at the border)
    assign w_addr_a = i_cmd.ann_step ? {r_gy, r_gx} : {r_y, r_x};
    assign w_addr_b = {r_gy, r_gx + 1'b1};

    always_ff @(posedge i_clk) begin
        r_qa <= r_mem[w_addr_a];
        r_qb <= r_mem[w_addr_b];
    end

    // below = previous result in this column, diagonal = previous right read
    assign w_border = ((SIDE_W'(r_px) + SIDE_W'(1)) >= r_w) ||
                      ((SIDE_W'(r_py) + SIDE_W'(1)) >= r_h);
    assign w_nb_obst = r_qb[CLR_W] | r_b[CLR_W] | r_d[CLR_W];

    always_comb begin
        w_min = r_qb[CLR_W-1:0];
        if (r_b[CLR_W-1:0] < w_min) begin
            w_min = r_b[CLR_W-1:0];
        end
        if (r_d[CLR_W-1:0] < w_min) begin
            w_min = r_d[CLR_W-1:0];
        end
    end

    assign w_inc = (w_min == CLR_MAX) ? CLR_MAX : w_min + 1'b1;

    always_comb begin
        priority if (r_qa[CLR_W]) begin
            w_new_clr = '0;
        end else if (w_border || w_nb_obst) begin
            w_new_clr = CLR_W'(1);
        end else begin
            w_new_clr = w_inc;
        end
    end

    assign w_ann_word = {r_qa[CLR_W], w_new_clr};

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_b <= w_ann_word;
            r_d <= r_qb;
        end
    end

    // single write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_y, r_x};
        w_wdata = {r_flag, {CLR_W{1'b0}}};
        priority if (i_cmd.clr_step) begin
            w_we    = 1'b1;
            w_waddr = r_clr_cnt;
            w_wdata = '0;
        end else if (r_pv) begin
            w_we    = 1'b1;
            w_waddr = {r_py, r_px};
            w_wdata = w_ann_word;
        end else if (i_cmd.wr_cell && w_in_range) begin
            w_we = 1'b1;
        end else begin
            w_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            unique case (r_op)
                OP_WRITE: begin
                    r_clearance <= '0;
                    r_blocked   <= w_in_range & r_flag;
                    r_oor       <= ~w_in_range;
                end
                OP_READ: begin
                    r_clearance <= (w_in_range && !r_qa[CLR_W]) ? r_qa[CLR_W-1:0] : '0;
                    r_blocked   <= w_in_range & r_qa[CLR_W];
                    r_oor       <= ~w_in_range;
                end
                OP_CLEAR, OP_ANNOTATE: begin
                    r_clearance <= '0;
                    r_blocked   <= 1'b0;
                    r_oor       <= 1'b0;
                end
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_clearance    = r_clearance;
    assign o_cell_blocked = r_blocked;
    assign o_out_of_range = r_oor;

endmodule

// ===== src/grid_clearance_annotator.sv =====
// Top level of the grid clearance annotator: controller plus datapath.
//
// A transaction is taken when start is high and busy is low; each one
// produces exactly one result, shown for a single cycle with o_done
// high. The receiver cannot stall, so results must be taken when shown.
// Write cell and read cell each touch one memory word, clear all
// obstacles sweeps one memory word per cycle over all 4096 cells, and
// annotate walks its width*height cells one per cycle through a
// two-stage read/compute pipeline on a 2-read, 1-write memory. After
// reset the block runs the same clearing pass with busy high and gives
// no result for it. o_done rises in the cycle after the last work cycle;
// busy is already low then, so the next transaction can start while the
// result is being shown. Configuration writes are always accepted
// (o_cfg_ready is tied high) and must only be issued while the block is
// idle; width and height are clamped to 1..64.
module grid_clearance_annotator import gca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [COORD_W-1:0] i_cell_x,
    input  logic [COORD_W-1:0] i_cell_y,
    input  logic               i_obstacle_flag,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [SIDE_W-1:0]  i_cfg_data,
    // result channel
    output logic               o_done,
    output logic [CLR_W-1:0]   o_clearance,
    output logic               o_cell_blocked,
    output logic               o_out_of_range
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    gca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .busy        (busy)
    );

    gca_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_operation     (i_operation),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_obstacle_flag (i_obstacle_flag),
        .i_cfg_valid     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_clearance     (o_clearance),
        .o_cell_blocked  (o_cell_blocked),
        .o_out_of_range  (o_out_of_range)
    );

endmodule

// ===== src/gca_checker.sv =====
// Port-level assertions for the grid clearance annotator, bound to the top level.
module gca_checker import gca_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [CLR_W-1:0]   o_clearance,
    input logic               o_cell_blocked,
    input logic               o_out_of_range
);

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // every transaction leaves idle for a work state before its result, so results never come back to back
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    // an out-of-range cell reports nothing else
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_of_range) |-> (!o_cell_blocked && (o_clearance == '0)))
        else $error("out-of-range result carries data");

    // an obstacle has zero clearance
    a_blocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_cell_blocked) |-> (o_clearance == '0))
        else $error("blocked cell with nonzero clearance");

endmodule

bind grid_clearance_annotator gca_checker u_gca_checker (.*);
